// ----- rtl/circular_deque_core_macros.svh -----
// Assertion helpers used by the deque core RTL.
// Each macro expects clk and rst_n in scope.
`ifndef CIRCULAR_DEQUE_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define CD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define CD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cd_pkg;

    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int OUTCOME_W = 2;
    localparam int ENTRY_W   = 5;

    // Reads as -1 on the signed result fields
    localparam logic [WORD_W-1:0] NOT_A_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_STATUS     = 3'd4
    } command_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_DONE  = 2'd0,
        OUTCOME_FULL  = 2'd1,
        OUTCOME_EMPTY = 2'd2
    } outcome_t;

    // What each cell of the row does on a given cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_WRITE_TAIL
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cd_cmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cd_cmd_if
    import cd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [WORD_W-1:0]  push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/cd_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cd_res_if
    import cd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [WORD_W-1:0]  popped_value;
    logic [OUTCOME_W-1:0]      outcome;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      is_empty;
    logic                      is_full;

    modport source (
        output valid, output popped_value, output outcome, output front_value,
        output back_value, output entry_count, output is_empty, output is_full,
        input ready
    );
    modport sink (
        input valid, input popped_value, input outcome, input front_value,
        input back_value, input entry_count, input is_empty, input is_full,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/circular_deque_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Fields
// cmd     | in  | command[2:0], push_value[31:0] signed
// res     | out | popped_value, outcome, front_value, back_value, entry_count,
//         |     | is_empty, is_full
//
// Each item passes S_IDLE, then S_EVAL: the accept edge shifts or writes the
// cell row, and S_EVAL gathers the front and back words into the result register.
// The front entry always sits in cell 0; the back is in cell count-1.
// Reset clears the count, the state and the result valid; cell words stay
// undefined until pushed. A stalled result holds; cmd ready drops until the
// pending result is taken.

`include "circular_deque_core_macros.svh"

module circular_deque_core
    import cd_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    cd_cmd_if.sink    cmd,
    cd_res_if.source  res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic {S_IDLE, S_EVAL} state_t;
    typedef enum logic [1:0] {POP_NONE, POP_FRONT, POP_BACK} pop_sel_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    outcome_t           outcome_reg;
    outcome_t           outcome_next;
    pop_sel_t           pop_sel_reg;
    pop_sel_t           pop_sel_next;
    logic [WORD_W-1:0]  pop_front_reg;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  popped_reg;
    logic [WORD_W-1:0]  front_reg;
    logic [WORD_W-1:0]  back_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               in_accept;
    logic               q_full;
    logic               q_empty;
    cell_ctl_t          cell_ctl;
    cell_op_t           op_sel;

    logic [WORD_W-1:0]  cell_data [CAPACITY];
    logic [CAPACITY-1:0] back_hit;
    logic [CAPACITY-1:0] next_hit;
    logic [WORD_W-1:0]  back_word;
    logic [WORD_W-1:0]  next_word;
    logic [WORD_W-1:0]  popped_word;

    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || res.ready);
    assign in_accept = cmd.valid && cmd.ready;
    assign q_full    = (count_reg == CNT_FULL);
    assign q_empty   = (count_reg == '0);

    // Decode the command against the current fill
    always_comb
    begin
        op_sel       = CELL_HOLD;
        count_next   = count_reg;
        outcome_next = OUTCOME_DONE;
        pop_sel_next = POP_NONE;
        unique case (command_t'(cmd.command))
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (q_full)
                begin
                    outcome_next = OUTCOME_FULL;
                end
                else
                begin
                    op_sel     = (command_t'(cmd.command) == CMD_PUSH_FRONT) ?
                                 CELL_SHIFT_UP : CELL_WRITE_TAIL;
                    count_next = count_reg + CNT_ONE;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (q_empty)
                begin
                    outcome_next = OUTCOME_EMPTY;
                end
                else
                begin
                    if (command_t'(cmd.command) == CMD_POP_FRONT)
                    begin
                        op_sel       = CELL_SHIFT_DOWN;
                        pop_sel_next = POP_FRONT;
                    end
                    else
                    begin
                        pop_sel_next = POP_BACK;
                    end
                    count_next = count_reg - CNT_ONE;
                end
            end
            default:
            begin
                op_sel = CELL_HOLD;
            end
        endcase
    end

    assign cell_ctl.op    = in_accept ? op_sel : CELL_HOLD;
    assign cell_ctl.value = cmd.push_value;

    // Row of cells, front in cell 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = cmd.push_value;
        end
        else
        begin : g_body_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_w = cell_data[i];
        end
        else
        begin : g_body_r
            assign right_w = cell_data[i+1];
        end

        cd_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .count      (count_reg),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .is_back    (back_hit[i]),
            .is_next    (next_hit[i])
        );
    end

    // Gather the back word and the word just past it (old back after a pop)
    always_comb
    begin
        back_word = '0;
        next_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_word = back_word | (cell_data[i] & {WORD_W{back_hit[i]}});
            next_word = next_word | (cell_data[i] & {WORD_W{next_hit[i]}});
        end
    end

    always_comb
    begin
        unique case (pop_sel_reg)
            POP_FRONT: popped_word = pop_front_reg;
            POP_BACK:  popped_word = next_word;
            default:   popped_word = NOT_A_VALUE;
        endcase
    end

    // Capture per-item data at accept, and the result fields in S_EVAL
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            outcome_reg   <= outcome_next;
            pop_sel_reg   <= pop_sel_next;
            pop_front_reg <= cell_data[0];
        end
        if (state_reg == S_EVAL)
        begin
            popped_reg    <= popped_word;
            front_reg     <= q_empty ? NOT_A_VALUE : cell_data[0];
            back_reg      <= q_empty ? NOT_A_VALUE : back_word;
            out_count_reg <= count_reg;
        end
    end

    // Sequence state, fill count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        count_reg <= count_next;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            priority if (state_reg == S_EVAL)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.popped_value = popped_reg;
    assign res.outcome      = outcome_reg;
    assign res.front_value  = front_reg;
    assign res.back_value   = back_reg;
    assign res.entry_count  = ENTRY_W'(out_count_reg);
    assign res.is_empty     = (out_count_reg == '0);
    assign res.is_full      = (out_count_reg == CNT_FULL);

    `CD_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_FULL, "fill count above capacity")
    `CD_ASSERT_NEXT(a_eval_after_accept, in_accept, state_reg == S_EVAL, "accept without eval")
    `CD_ASSERT_NOW(a_eval_out_free, state_reg == S_EVAL, !out_valid_reg, "result overwritten")
    `CD_ASSERT_NOW(a_empty_values, res.valid && res.is_empty,
        (front_reg == NOT_A_VALUE) && (back_reg == NOT_A_VALUE), "empty deque shows values")
    `CD_ASSERT_NOW(a_reject_pop, res.valid && (res.outcome != OUTCOME_DONE),
        popped_reg == NOT_A_VALUE, "rejected item popped a value")

endmodule

`default_nettype wire

// ----- rtl/cd_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cd_cell
    import cd_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
)
(
    input  wire logic              clk,
    input  wire cell_ctl_t         ctl,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [WORD_W-1:0] left_data,
    input  wire logic [WORD_W-1:0] right_data,
    output logic [WORD_W-1:0]      data,
    output logic                   is_back,
    output logic                   is_next
);

    localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] POS_PLUS = CNT_W'(INDEX + 1);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    // Position flags against the held count
    assign is_back = (count == POS_PLUS);
    assign is_next = (count == POS);
    assign data    = data_reg;

    // Take from a neighbor, take the pushed word, or hold
    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_SHIFT_UP:   data_next = left_data;
            CELL_SHIFT_DOWN: data_next = right_data;
            CELL_WRITE_TAIL:
            begin
                if (is_next)
                begin
                    data_next = ctl.value;
                end
            end
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ----- bench/tb_circular_deque_core.sv -----
`timescale 1ns / 1ps

module tb_circular_deque_core;
    import cd_pkg::*;

    localparam int CAPACITY = 16;

    // Spare command codes decode as a status read
    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;

    localparam int RANDOM_ITEMS = 550;
    localparam int BIAS_SPAN    = 48;
    localparam int MAX_IDLE     = 10;

    typedef struct packed {
        logic [WORD_W-1:0]    popped;
        logic [OUTCOME_W-1:0] outcome;
        logic [WORD_W-1:0]    front;
        logic [WORD_W-1:0]    back;
        logic [ENTRY_W-1:0]   count;
        logic                 empty;
        logic                 full;
    } deque_report_t;

    typedef struct packed {
        bit            typed;
        deque_report_t want;
    } typed_report_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [WORD_W-1:0] value;
        logic [4:0]        reps;
        bit                typed;
        deque_report_t     want;
    } stim_row_t;

    localparam deque_report_t RPT_EMPTY_STATUS = '{NOT_A_VALUE, OUTCOME_DONE,
        NOT_A_VALUE, NOT_A_VALUE, 5'd0, 1'b1, 1'b0};
    localparam deque_report_t RPT_EMPTY_REJECT = '{NOT_A_VALUE, OUTCOME_EMPTY,
        NOT_A_VALUE, NOT_A_VALUE, 5'd0, 1'b1, 1'b0};
    localparam deque_report_t RPT_FULL_REJECT  = '{NOT_A_VALUE, OUTCOME_FULL,
        32'h8000_0000, 32'h7FFF_FFFF, 5'd16, 1'b0, 1'b1};
    localparam deque_report_t RPT_NONE = '0;

    localparam int DIRECTED_ROWS = 21;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_STATUS,     32'h0000_0000, 5'd1,  1'b1, RPT_EMPTY_STATUS},
        '{CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, RPT_EMPTY_REJECT},
        '{CMD_POP_BACK,   32'hFFFF_FFFF, 5'd1,  1'b1, RPT_EMPTY_REJECT},
        // front push into an empty deque
        '{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 5'd1,  1'b0, RPT_NONE},
        '{CMD_STATUS,     32'h0000_0000, 5'd1,  1'b0, RPT_NONE},
        '{CMD_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, RPT_NONE},
        '{CMD_PUSH_BACK,  32'h8000_0000, 5'd1,  1'b0, RPT_NONE},
        '{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1,  1'b0, RPT_NONE},
        '{CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, RPT_NONE},
        '{CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, RPT_NONE},
        // spare codes behave as status reads
        '{CMD_UNUSED_A,   32'h1234_5678, 5'd1,  1'b1, RPT_EMPTY_STATUS},
        '{CMD_UNUSED_B,   32'hFFFF_FFFF, 5'd1,  1'b1, RPT_EMPTY_STATUS},
        '{CMD_UNUSED_C,   32'h0000_0000, 5'd1,  1'b1, RPT_EMPTY_STATUS},
        // fill to capacity with extremes at both ends
        '{CMD_PUSH_BACK,  32'h8000_0000, 5'd1,  1'b0, RPT_NONE},
        '{CMD_PUSH_BACK,  32'h0000_0000, 5'd14, 1'b0, RPT_NONE},
        '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 5'd1,  1'b0, RPT_NONE},
        '{CMD_PUSH_FRONT, 32'h0000_1234, 5'd1,  1'b1, RPT_FULL_REJECT},
        '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 5'd1,  1'b1, RPT_FULL_REJECT},
        '{CMD_STATUS,     32'h0000_0000, 5'd1,  1'b0, RPT_NONE},
        '{CMD_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, RPT_NONE},
        '{CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, RPT_NONE}
    };

    logic clk = 1'b0;
    logic rst_n;

    cd_cmd_if cmd_ch ();
    cd_res_if res_ch ();

    circular_deque_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Shadow copy of the deque
    logic [WORD_W-1:0]  shadow_ring [CAPACITY];
    logic [3:0]         shadow_head;
    logic [ENTRY_W-1:0] shadow_held;

    deque_report_t queued_reports [$];
    typed_report_t typed_reports  [$];
    deque_report_t predicted;
    deque_report_t observed;
    typed_report_t typed_tag;

    int mismatch_count = 0;
    int sent_items     = 0;
    int taken_reports  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the shadow deque by one command and report what it shows after
    function automatic deque_report_t deque_step(logic [CMD_W-1:0] op,
                                                 logic [WORD_W-1:0] value);
        deque_report_t rpt;
        logic [3:0]    slot;
        rpt         = '0;
        rpt.popped  = NOT_A_VALUE;
        rpt.outcome = OUTCOME_DONE;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_held == CAPACITY)
                    rpt.outcome = OUTCOME_FULL;
                else if (op == CMD_PUSH_FRONT)
                begin
                    shadow_head              = shadow_head - 4'd1;
                    shadow_ring[shadow_head] = value;
                    shadow_held              = shadow_held + 5'd1;
                end
                else
                begin
                    slot              = shadow_head + shadow_held[3:0];
                    shadow_ring[slot] = value;
                    shadow_held       = shadow_held + 5'd1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (shadow_held == 0)
                    rpt.outcome = OUTCOME_EMPTY;
                else
                begin
                    rpt.popped  = shadow_ring[shadow_head];
                    shadow_head = shadow_head + 4'd1;
                    shadow_held = shadow_held - 5'd1;
                end
            end
            CMD_POP_BACK:
            begin
                if (shadow_held == 0)
                    rpt.outcome = OUTCOME_EMPTY;
                else
                begin
                    slot        = shadow_head + shadow_held[3:0] - 4'd1;
                    rpt.popped  = shadow_ring[slot];
                    shadow_held = shadow_held - 5'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (shadow_held == 0)
        begin
            rpt.front = NOT_A_VALUE;
            rpt.back  = NOT_A_VALUE;
        end
        else
        begin
            slot      = shadow_head + shadow_held[3:0] - 4'd1;
            rpt.front = shadow_ring[shadow_head];
            rpt.back  = shadow_ring[slot];
        end
        rpt.count = shadow_held;
        rpt.empty = (shadow_held == 0);
        rpt.full  = (shadow_held == CAPACITY);
        return rpt;
    endfunction

    task automatic compare_report(deque_report_t want, deque_report_t got);
        if (got.popped !== want.popped)
        begin
            $error("popped_value: expected %0d, got %0d", $signed(want.popped),
                   $signed(got.popped));
            mismatch_count++;
        end
        if (got.outcome !== want.outcome)
        begin
            $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
            mismatch_count++;
        end
        if (got.front !== want.front)
        begin
            $error("front_value: expected %0d, got %0d", $signed(want.front),
                   $signed(got.front));
            mismatch_count++;
        end
        if (got.back !== want.back)
        begin
            $error("back_value: expected %0d, got %0d", $signed(want.back),
                   $signed(got.back));
            mismatch_count++;
        end
        if (got.count !== want.count)
        begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            mismatch_count++;
        end
        if (got.empty !== want.empty)
        begin
            $error("is_empty: expected %0b, got %0b", want.empty, got.empty);
            mismatch_count++;
        end
        if (got.full !== want.full)
        begin
            $error("is_full: expected %0b, got %0b", want.full, got.full);
            mismatch_count++;
        end
    endtask

    // Lean toward pushes while growing and toward pops while shrinking
    function automatic logic [CMD_W-1:0] pick_command(bit grow);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (grow ? 60 : 25))
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (roll < 88)
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (roll < 96)
            return CMD_STATUS;
        else
            case ($urandom_range(0, 2))
                0:       return CMD_UNUSED_A;
                1:       return CMD_UNUSED_B;
                default: return CMD_UNUSED_C;
            endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item after a random gap (none in back-to-back stretches) and hold it until it is taken
    task automatic offer_item(logic [CMD_W-1:0] op, logic [WORD_W-1:0] value,
                              bit typed, deque_report_t want);
        int gap;
        gap = (((sent_items / 40) % 4) == 3) ? 0 : $urandom_range(0, MAX_IDLE);
        typed_reports.push_back('{typed, want});
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= op;
        cmd_ch.push_value <= value;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sent_items++;
    endtask

    // Predict on every accepted command
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            predicted = deque_step(cmd_ch.command, cmd_ch.push_value);
            typed_tag = typed_reports.pop_front();
            queued_reports.push_back(typed_tag.typed ? typed_tag.want : predicted);
        end
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            observed = '{res_ch.popped_value, res_ch.outcome, res_ch.front_value,
                         res_ch.back_value, res_ch.entry_count, res_ch.is_empty,
                         res_ch.is_full};
            if (queued_reports.size() == 0)
            begin
                $error("result with no expected item pending");
                mismatch_count++;
            end
            else
                compare_report(queued_reports.pop_front(), observed);
        end
    end

    // Stall the result side at random, with quiet stretches
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = (((taken_reports / 40) % 4) == 1) ? 0
                                                      : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            taken_reports++;
        end
    end

    // Reset, walk the directed table, then random traffic, then drain
    initial
    begin
        bit grow;
        grow               = 1'b0;
        shadow_head        = '0;
        shadow_held        = '0;
        foreach (shadow_ring[i])
            shadow_ring[i] = '0;
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_STATUS;
        cmd_ch.push_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                offer_item(directed_rows[r].op, directed_rows[r].value,
                           directed_rows[r].typed, directed_rows[r].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ((n % BIAS_SPAN) == 0)
                grow = !grow;
            offer_item(pick_command(grow), pick_value(), 1'b0, RPT_NONE);
        end
        cmd_ch.valid <= 1'b0;

        // Let the predictor queue the last accepted item before draining
        @(posedge clk);
        while (queued_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
